FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion violated");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/cmmn_pkg.sv
// types and constants of the column min-max normalizer
// no dependencies
`default_nettype none

package cmmn_pkg;

  localparam int VALUE_W    = 16;
  localparam int RESULT_W   = 17;
  localparam int ROW_NUM_W  = 3;
  localparam int COL_NUM_W  = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_W      = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // fixed point
  localparam int FRAC_W   = 15;
  localparam int QUO_W    = 16;
  localparam int QUO_MAX  = 2 ** FRAC_W;
  localparam int VAL_MAX  = 2 ** (VALUE_W - 1) - 1;
  localparam int VAL_MIN  = -(2 ** (VALUE_W - 1));
  localparam int DIFF_W   = VALUE_W + 1;
  localparam int REM_W    = VALUE_W + 2;
  localparam int PROD_W   = 2 * VALUE_W + 1;
  localparam int SHIFT_W  = PROD_W + 1 - FRAC_W;
  localparam int DN_SUM_W = VALUE_W + 4;

  // divider: quotient bits retired per cycle
  localparam int DIV_PER_CYCLE = 4;
  localparam int DIV_CYCLES    = QUO_W / DIV_PER_CYCLE;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

  // commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DENORM = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_CONST = 2'd1;
  localparam status_t ST_DROP  = 2'd2;
  localparam status_t ST_SAT   = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t col_max;
    value_t col_min;
  } stat_entry_t;

endpackage

`default_nettype wire

FILE: rtl/column_min_max_normalizer_core.sv
// column min-max normalizer: sample store, column statistics, divider and denormalizer
// depends on cmmn_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Usage
// in channel: in_tuser selects the command (0 load, 1 denormalize), in_tdata carries
//   the value and the column, in_tlast marks the final sample of a matrix
// out channel: out_tdata carries result, row and column, out_tuser the status,
//   out_tlast the last result of a run (always set for denormalize)
// cfg_wr_en/cfg_wr_data set the row width; the user must write it only while the block
//   is idle, the block itself does not enforce this
// Sequence
// a load request: the sample is written to the store while the column
//   statistics are read, then min/max are written back
// a denormalize request: stats read, 16x17 multiply, then round and saturate
//   into the output register once that register is free
// after the last sample each result goes through store and stats read, prep,
//   the radix-16 divider for the 16-bit quotient and output load; a constant
//   column skips the divider
// Reset: counters and the overflow flag clear, statistics read as zero until
//   first written, width goes to MAX_COLUMNS; the sample store is not cleared
// Stall: a result waits in the output register; a new request is taken as soon
//   as the block is idle, and the emit walk holds until the register frees up
module column_min_max_normalizer_core #(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLUMNS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [cmmn_pkg::CFG_W-1:0]      cfg_wr_data,   // columns_in_use
  // request channel
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [cmmn_pkg::IN_DATA_W-1:0]  in_tdata,      // sample_value, column_index
  input  wire logic                            in_tuser,      // command
  input  wire logic                            in_tlast,      // last_sample
  // result channel
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [cmmn_pkg::OUT_DATA_W-1:0]      out_tdata,     // result_value, row, column
  output cmmn_pkg::status_t                    out_tuser,     // status
  output logic                                 out_tlast      // final_result
);
  import cmmn_pkg::*;

  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CCNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PAD_W  = OUT_DATA_W - RESULT_W - ROW_NUM_W - COL_NUM_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_E_RD   = 3'd2;
  localparam logic [2:0] S_E_PREP = 3'd3;
  localparam logic [2:0] S_E_DIV  = 3'd4;
  localparam logic [2:0] S_E_OUT  = 3'd5;
  localparam logic [2:0] S_DN_MUL = 3'd6;
  localparam logic [2:0] S_DN_OUT = 3'd7;

  localparam logic signed [DN_SUM_W-1:0] SAT_HI = DN_SUM_W'(VAL_MAX);
  localparam logic signed [DN_SUM_W-1:0] SAT_LO = DN_SUM_W'(VAL_MIN);

  logic [2:0] state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0]  cfg_cols_r;
  logic [CCNT_W-1:0] cols_act;

  // load counters
  logic [RCNT_W-1:0] rc_r;
  logic [CCNT_W-1:0] cc_r;
  logic              ovf_r;

  // request decode
  logic               in_acc;
  value_t             in_val;
  logic [2:0]         in_cidx;
  logic [COL_W-1:0]   dn_col;

  // load position logic
  logic              wrap0, wrap1, ld_store;
  logic [CCNT_W-1:0] ld_c, ld_c_inc;
  logic [RCNT_W-1:0] ld_r;
  logic [ADDR_W-1:0] ld_addr;

  // latched load request
  value_t            ld_v_r;
  logic [COL_W-1:0]  ld_col_r;
  logic              ld_first_r, ld_store_r, ld_last_r;

  // memories
  value_t            store_mem [DEPTH];
  value_t            store_rd_r;
  stat_entry_t       stat_mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] stat_vld_r;
  stat_entry_t       stat_rd_r, stat_q, stat_wr;
  logic              stat_hit_r;
  logic              stat_rd_en;
  logic [COL_W-1:0]  stat_rd_addr;

  // emit walk
  logic [RCNT_W-1:0] er_r, e_full_r, snap_full, nr;
  logic [CCNT_W-1:0] ec_r, e_part_r, e_cols_r, snap_part, nc, ec_inc;
  logic              e_ovf_r, e_const_r, snap_any, next_valid, e_wrap;
  logic [ADDR_W-1:0] e_addr;

  // normalize datapath
  logic signed [DIFF_W-1:0] diff, dx, dclamp;
  logic                     is_const;
  logic [REM_W-1:0]         rem_r, dvs_r, rem_v, rem_s;
  logic [VALUE_W-1:0]       lo_r, lo_v;
  logic [QUO_W-1:0]         quo_r, q_v;
  logic [DIV_CNT_W-1:0]     div_cnt_r;

  // denormalize datapath
  value_t                     dn_v_r, dn_min_r;
  logic [COL_W-1:0]           dn_col_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [DIFF_W-1:0]   dn_diff;
  logic signed [PROD_W:0]     dn_rnd;
  logic signed [SHIFT_W-1:0]  dn_sh;
  logic signed [DN_SUM_W-1:0] dn_sum;
  logic signed [RESULT_W-1:0] dn_res;
  status_t                    dn_st;

  // output register
  logic                out_valid_r, out_free, out_load;
  logic [RESULT_W-1:0] out_res_r, out_res_nxt;
  logic [ROW_NUM_W-1:0] out_row_r, out_row_nxt;
  logic [COL_NUM_W-1:0] out_col_r, out_col_nxt;
  logic                out_last_r, out_last_nxt;
  status_t             out_st_r, out_st_nxt;

  // ---------------------------------------------------------------------------
  // request decode and width clamp
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign in_val    = value_t'(in_tdata[VALUE_W-1:0]);
  assign in_cidx   = in_tdata[VALUE_W +: COL_NUM_W];

  always_comb begin
    if (cfg_cols_r == '0) begin
      cols_act = CCNT_W'(1);
    end else if (cfg_cols_r > CFG_W'(MAX_COLUMNS)) begin
      cols_act = CCNT_W'(MAX_COLUMNS);
    end else begin
      cols_act = CCNT_W'(cfg_cols_r);
    end
  end

  // out-of-range column folds onto the last one
  always_comb begin
    if ({1'b0, in_cidx} >= 4'(MAX_COLUMNS)) begin
      dn_col = COL_W'(MAX_COLUMNS - 1);
    end else begin
      dn_col = COL_W'(in_cidx);
    end
  end

  // ---------------------------------------------------------------------------
  // load position: wrap left over from a width change, then advance
  always_comb begin
    wrap0    = (cc_r >= cols_act);
    ld_c     = wrap0 ? '0 : cc_r;
    ld_r     = (wrap0 && (rc_r < RCNT_W'(MAX_ROWS))) ? rc_r + 1'b1 : rc_r;
    ld_store = (ld_r < RCNT_W'(MAX_ROWS));
    ld_c_inc = ld_c + 1'b1;
    wrap1    = (ld_c_inc >= cols_act);
    ld_addr  = ADDR_W'(ADDR_W'(ld_r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(ld_c));
  end

  // ---------------------------------------------------------------------------
  // emit walk bookkeeping
  always_comb begin
    snap_full = rc_r;
    snap_part = (rc_r < RCNT_W'(MAX_ROWS)) ? cc_r : '0;
    snap_any  = (snap_full != '0) || (snap_part != '0);
    ec_inc    = ec_r + 1'b1;
    e_wrap    = (ec_inc >= e_cols_r);
    nr        = e_wrap ? er_r + 1'b1 : er_r;
    nc        = e_wrap ? '0 : ec_inc;
    next_valid = (nr < e_full_r) || ((nr == e_full_r) && (nc < e_part_r));
    e_addr    = ADDR_W'(ADDR_W'(er_r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(ec_r));
  end

  // ---------------------------------------------------------------------------
  // statistics memory: one read port, one write port, valid bits for reset
  always_comb begin
    stat_rd_en   = 1'b0;
    stat_rd_addr = ld_c[COL_W-1:0];
    if (in_acc) begin
      stat_rd_en   = 1'b1;
      stat_rd_addr = (in_tuser == CMD_DENORM) ? dn_col : ld_c[COL_W-1:0];
    end else if (state_r == S_E_RD) begin
      stat_rd_en   = 1'b1;
      stat_rd_addr = ec_r[COL_W-1:0];
    end
  end

  assign stat_q = stat_hit_r ? stat_rd_r : '0;

  // first row sets the range, later rows widen it
  always_comb begin
    stat_wr = stat_q;
    if (ld_first_r) begin
      stat_wr.col_min = ld_v_r;
      stat_wr.col_max = ld_v_r;
    end else begin
      if (ld_v_r < stat_q.col_min) stat_wr.col_min = ld_v_r;
      if (ld_v_r > stat_q.col_max) stat_wr.col_max = ld_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stat_rd_en) begin
      stat_rd_r  <= stat_mem[stat_rd_addr];
      stat_hit_r <= stat_vld_r[stat_rd_addr];
    end
    if ((state_r == S_LOAD) && ld_store_r) begin
      stat_mem[ld_col_r] <= stat_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_vld_r <= '0;
    end else if ((state_r == S_LOAD) && ld_store_r) begin
      stat_vld_r[ld_col_r] <= 1'b1;
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == CMD_LOAD) && ld_store) begin
      store_mem[ld_addr] <= in_val;
    end
    if (state_r == S_E_RD) begin
      store_rd_r <= store_mem[e_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // normalize: clamp x - min into [0, diff], then q = (d*2^16 + diff) / (2*diff)
  always_comb begin
    diff     = DIFF_W'(stat_q.col_max) - DIFF_W'(stat_q.col_min);
    dx       = DIFF_W'(store_rd_r) - DIFF_W'(stat_q.col_min);
    is_const = (diff <= 0);
    if (dx < 0) begin
      dclamp = '0;
    end else if (dx > diff) begin
      dclamp = diff;
    end else begin
      dclamp = dx;
    end
  end

  // restoring divider, DIV_PER_CYCLE quotient bits a cycle
  always_comb begin
    rem_v = rem_r;
    lo_v  = lo_r;
    q_v   = quo_r;
    rem_s = '0;
    for (int i = 0; i < DIV_PER_CYCLE; i++) begin
      rem_s = {rem_v[REM_W-2:0], lo_v[VALUE_W-1]};
      lo_v  = {lo_v[VALUE_W-2:0], 1'b0};
      if (rem_s >= dvs_r) begin
        rem_v = rem_s - dvs_r;
        q_v   = {q_v[QUO_W-2:0], 1'b1};
      end else begin
        rem_v = rem_s;
        q_v   = {q_v[QUO_W-2:0], 1'b0};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // denormalize: min + floor((v*diff + 2^14) / 2^15), saturated
  always_comb begin
    dn_diff = (diff < 0) ? '0 : diff;
    dn_rnd  = {prod_r[PROD_W-1], prod_r} + (PROD_W + 1)'(2 ** (FRAC_W - 1));
    dn_sh   = dn_rnd[PROD_W:FRAC_W];
    dn_sum  = DN_SUM_W'(dn_min_r) + DN_SUM_W'(dn_sh);
    dn_st   = ST_OK;
    if (dn_sum > SAT_HI) begin
      dn_res = RESULT_W'(SAT_HI);
      dn_st  = ST_SAT;
    end else if (dn_sum < SAT_LO) begin
      dn_res = RESULT_W'(SAT_LO);
      dn_st  = ST_SAT;
    end else begin
      dn_res = RESULT_W'(dn_sum);
    end
  end

  // ---------------------------------------------------------------------------
  // output register load
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    out_load     = 1'b0;
    out_res_nxt  = out_res_r;
    out_row_nxt  = out_row_r;
    out_col_nxt  = out_col_r;
    out_last_nxt = out_last_r;
    out_st_nxt   = out_st_r;
    if ((state_r == S_E_OUT) && out_free) begin
      out_load     = 1'b1;
      out_res_nxt  = e_const_r ? '0 : RESULT_W'(quo_r);
      out_row_nxt  = ROW_NUM_W'(er_r);
      out_col_nxt  = COL_NUM_W'(ec_r);
      out_last_nxt = !next_valid;
      out_st_nxt   = e_const_r ? ST_CONST : ST_OK;
      if (!next_valid && e_ovf_r) out_st_nxt = ST_DROP;
    end else if ((state_r == S_DN_OUT) && out_free) begin
      out_load     = 1'b1;
      out_res_nxt  = dn_res;
      out_row_nxt  = '0;
      out_col_nxt  = COL_NUM_W'(dn_col_r);
      out_last_nxt = 1'b1;
      out_st_nxt   = dn_st;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
    out_st_r   <= out_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_col_r, out_row_r, out_res_r};
  assign out_tuser  = out_st_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = (in_tuser == CMD_DENORM) ? S_DN_MUL : S_LOAD;
      end
      S_LOAD: begin
        if (ld_last_r) state_nxt = snap_any ? S_E_RD : S_IDLE;
        else           state_nxt = S_IDLE;
      end
      S_E_RD:   state_nxt = S_E_PREP;
      S_E_PREP: state_nxt = is_const ? S_E_OUT : S_E_DIV;
      S_E_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) state_nxt = S_E_OUT;
      end
      S_E_OUT: begin
        if (out_free) state_nxt = next_valid ? S_E_RD : S_IDLE;
      end
      S_DN_MUL: state_nxt = S_DN_OUT;
      S_DN_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cfg_cols_r <= CFG_W'(MAX_COLUMNS);
      rc_r       <= '0;
      cc_r       <= '0;
      ovf_r      <= 1'b0;
      er_r       <= '0;
      ec_r       <= '0;
      div_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) cfg_cols_r <= cfg_wr_data;
      if (in_acc && (in_tuser == CMD_LOAD)) begin
        cc_r <= wrap1 ? '0 : ld_c_inc;
        rc_r <= (wrap1 && ld_store) ? ld_r + 1'b1 : ld_r;
        if (!ld_store) ovf_r <= 1'b1;
      end
      // run ends: counters restart, statistics stay
      if ((state_r == S_LOAD) && ld_last_r) begin
        rc_r  <= '0;
        cc_r  <= '0;
        ovf_r <= 1'b0;
        er_r  <= '0;
        ec_r  <= '0;
      end
      if ((state_r == S_E_OUT) && out_free) begin
        er_r <= nr;
        ec_r <= nc;
      end
      if (state_r == S_E_PREP) div_cnt_r <= '0;
      else if (state_r == S_E_DIV) div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ld_v_r     <= in_val;
      ld_col_r   <= ld_c[COL_W-1:0];
      ld_first_r <= (ld_r == '0);
      ld_store_r <= ld_store;
      ld_last_r  <= in_tlast;
      dn_v_r     <= in_val;
      dn_col_r   <= dn_col;
    end
    if (state_r == S_LOAD) begin
      e_full_r <= snap_full;
      e_part_r <= snap_part;
      e_cols_r <= cols_act;
      e_ovf_r  <= ovf_r;
    end
    if (state_r == S_E_PREP) begin
      e_const_r <= is_const;
      rem_r     <= REM_W'(unsigned'(dclamp));
      dvs_r     <= {1'b0, diff[VALUE_W-1:0], 1'b0};
      lo_r      <= diff[VALUE_W-1:0];
      quo_r     <= '0;
    end else if (state_r == S_E_DIV) begin
      rem_r <= rem_v;
      lo_r  <= lo_v;
      quo_r <= q_v;
    end
    if (state_r == S_DN_MUL) begin
      prod_r   <= dn_v_r * dn_diff;
      dn_min_r <= stat_q.col_min;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  `ASSERT_ALWAYS(a_col_cnt_bound, clk, rst_n, cc_r < CCNT_W'(MAX_COLUMNS))
  `ASSERT_IMPL(a_ovf_only_when_full, clk, rst_n, ovf_r, rc_r == RCNT_W'(MAX_ROWS))
  `ASSERT_IMPL(a_quo_bound, clk, rst_n, (state_r == S_E_OUT) && !e_const_r, quo_r <= QUO_W'(QUO_MAX))

endmodule

`default_nettype wire

FILE: sim/column_min_max_normalizer_core_tb.sv
// self-checking testbench for column_min_max_normalizer_core
// holds its own bit-accurate predictor of load and denormalize requests
// depends on cmmn_pkg and the rtl of the core
`timescale 1ns / 100ps

module column_min_max_normalizer_core_tb;
  import cmmn_pkg::*;

  localparam int MAX_ROWS     = 8;
  localparam int MAX_COLS     = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_TIME  = 24;    // covers the emit step with margin
  localparam int RANDOM_ITEMS = 230;
  localparam int SHOWN_ERRORS = 10;

  // one result as it leaves the block
  typedef struct packed {
    logic [RESULT_W-1:0]  value;
    logic [ROW_NUM_W-1:0] row;
    logic [COL_NUM_W-1:0] col;
    logic                 is_final;
    status_t              status;
  } scaled_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_W-1:0]      cfg_wr_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;     // sample_value, column_index, zero pad
  logic                  in_tuser;     // command
  logic                  in_tlast;     // last_sample
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;    // result_value, row_number, column_number, zero pad
  status_t               out_tuser;    // status
  logic                  out_tlast;    // final_result

  column_min_max_normalizer_core #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  // predictor state, mirrors what the block holds
  value_t           stored_sample [MAX_ROWS*MAX_COLS];
  value_t           col_lo [MAX_COLS];
  value_t           col_hi [MAX_COLS];
  int               rows_seen;
  int               cols_seen;
  bit               rows_dropped;
  logic [CFG_W-1:0] row_width_reg;

  scaled_result_t   scaled_outputs [$];   // oldest expected result first
  int               mismatches;
  int               requests_sent;
  int               cycle_count;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               hold_cycles;         // receiver hold-off length, counted below

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // every input known from time zero
  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_LOAD;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // register value as the block interprets it: 0 means one column, above 8 means 8
  function automatic int active_width();
    if (row_width_reg == 0) return 1;
    if (row_width_reg > MAX_COLS) return MAX_COLS;
    return int'(row_width_reg);
  endfunction

  // (x-min)/(max-min) in unsigned q1.15, halves rounded up; flat column gives 0
  function automatic logic [RESULT_W-1:0] unit_scale(input value_t x, input int c,
                                                     output status_t st);
    longint lo, span, d;
    lo   = longint'(col_lo[c]);
    span = longint'(col_hi[c]) - lo;
    d    = longint'(x) - lo;
    if (span <= 0) begin
      st = ST_CONST;
      return '0;
    end
    st = ST_OK;
    if (d < 0) d = 0;
    if (d > span) d = span;
    return RESULT_W'((d * 65536 + span) / (2 * span));
  endfunction

  // works out every result one accepted request causes, in emission order
  task automatic compute_scaled_outputs(input logic cmd, input value_t value,
                                        input logic [COL_NUM_W-1:0] column, input logic last);
    int             cols, full, part, total, k;
    longint         span, restored;
    status_t        st;
    scaled_result_t res;
    cols = active_width();

    if (cmd == CMD_DENORM) begin
      // q1.15 back to q8.8 using the statistics as they stand now
      span = longint'(col_hi[column]) - longint'(col_lo[column]);
      if (span < 0) span = 0;
      restored = longint'(col_lo[column]) + ((longint'(value) * span + 16384) >>> FRAC_W);
      st = ST_OK;
      if (restored > VAL_MAX) begin
        restored = VAL_MAX;
        st = ST_SAT;
      end
      if (restored < VAL_MIN) begin
        restored = VAL_MIN;
        st = ST_SAT;
      end
      res.value    = restored[RESULT_W-1:0];
      res.row      = '0;
      res.col      = column;
      res.is_final = 1'b1;
      res.status   = st;
      scaled_outputs = {scaled_outputs, res};
      return;
    end

    // load: store the sample and widen the column's range
    if (cols_seen >= cols) begin
      cols_seen = 0;
      if (rows_seen < MAX_ROWS) rows_seen++;
    end
    if (rows_seen < MAX_ROWS) begin
      stored_sample[rows_seen*MAX_COLS + cols_seen] = value;
      if (rows_seen == 0) begin
        // first row seeds the range
        col_lo[cols_seen] = value;
        col_hi[cols_seen] = value;
      end else begin
        if (value < col_lo[cols_seen]) col_lo[cols_seen] = value;
        if (value > col_hi[cols_seen]) col_hi[cols_seen] = value;
      end
    end else begin
      rows_dropped = 1'b1;
    end
    cols_seen++;
    if (cols_seen >= cols) begin
      cols_seen = 0;
      if (rows_seen < MAX_ROWS) rows_seen++;
    end

    if (!last) return;

    // emit walk: full rows, then whatever of the partial row was loaded
    full  = (rows_seen > MAX_ROWS) ? MAX_ROWS : rows_seen;
    part  = (full < MAX_ROWS) ? cols_seen : 0;
    if (part > cols) part = cols;
    total = full * cols + part;
    k     = 0;
    for (int r = 0; r <= full; r++) begin
      for (int c = 0; c < ((r < full) ? cols : part); c++) begin
        res.value    = unit_scale(stored_sample[r*MAX_COLS + c], c, st);
        res.row      = ROW_NUM_W'(r);
        res.col      = COL_NUM_W'(c);
        res.is_final = (k == total - 1);
        res.status   = (k == total - 1 && rows_dropped) ? ST_DROP : st;
        scaled_outputs = {scaled_outputs, res};
        k++;
      end
    end
    rows_seen    = 0;
    cols_seen    = 0;
    rows_dropped = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result side: receiver back-pressure and checking
  // ---------------------------------------------------------------------------

  // random stalls, or a long hold-off while hold_cycles runs down
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready  = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input scaled_result_t want,
                                 input scaled_result_t got);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) begin
      $display("%0d: %s  expected val=%0d row=%0d col=%0d final=%0b st=%0d",
               cycle_count, what, $signed(want.value), want.row, want.col,
               want.is_final, want.status);
      $display("%0d: %s  got      val=%0d row=%0d col=%0d final=%0b st=%0d",
               cycle_count, what, $signed(got.value), got.row, got.col,
               got.is_final, got.status);
    end
  endtask

  scaled_result_t got_result, want_result;

  // each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_result.value    = out_tdata[RESULT_W-1:0];
      got_result.row      = out_tdata[RESULT_W +: ROW_NUM_W];
      got_result.col      = out_tdata[RESULT_W+ROW_NUM_W +: COL_NUM_W];
      got_result.is_final = out_tlast;
      got_result.status   = out_tuser;
      if (scaled_outputs.size() == 0) begin
        report_mismatch("unexpected result", '0, got_result);
      end else begin
        want_result = scaled_outputs.pop_front();
        if (got_result.value !== want_result.value || got_result.row !== want_result.row ||
            got_result.col !== want_result.col || got_result.is_final !== want_result.is_final ||
            got_result.status !== want_result.status)
          report_mismatch("result mismatch", want_result, got_result);
      end
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request; valid stays up from the last acceptance unless a gap is drawn
  task automatic send_request(input logic cmd, input value_t value,
                              input logic [COL_NUM_W-1:0] column, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {{(IN_DATA_W-VALUE_W-COL_NUM_W){1'b0}}, column, value};
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    compute_scaled_outputs(cmd, value, column, last);
    requests_sent++;
  endtask

  // drop valid and let the block drain before touching the register
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (scaled_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);
  endtask

  task automatic write_row_width(input logic [CFG_W-1:0] width);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = width;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    row_width_reg = width;
  endtask

  // feature values: flat, narrow, extreme or anything
  function automatic value_t pick_feature(input int mode, input value_t base);
    case (mode)
      0: return base;
      1: return base + value_t'($urandom_range(1));
      2: begin
        case ($urandom_range(3))
          0: return value_t'(VAL_MIN);
          1: return value_t'(VAL_MAX);
          2: return '0;
          default: return '1;
        endcase
      end
      default: return value_t'($urandom);
    endcase
  endfunction

  // one matrix with random shape and content, denormalize requests mixed in
  task automatic run_random_matrix();
    int     cols, rows, count, mode;
    value_t base;
    cols  = active_width();
    rows  = ($urandom_range(7) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 3);
    count = rows * cols;
    if ($urandom_range(2) == 0) count = count - $urandom_range(0, cols - 1);
    if (count < 1) count = 1;
    mode  = $urandom_range(9);
    base  = value_t'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 12)
        send_request(CMD_DENORM, value_t'($urandom), COL_NUM_W'($urandom_range(7)),
                     1'($urandom_range(1)));
      send_request(CMD_LOAD, pick_feature(mode, base), COL_NUM_W'($urandom_range(7)),
                   i == count - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // statistics are zero after reset, so any value restores to zero
  task automatic test_denorm_after_reset();
    send_request(CMD_DENORM, value_t'(VAL_MAX), 3'd0, 1'b1);
    send_request(CMD_DENORM, value_t'(VAL_MIN), 3'd7, 1'b0);
    wait_idle();
  endtask

  // three columns: full-range, flat and symmetric, with a partial last row
  task automatic test_extremes_and_flat_column();
    write_row_width(4'd3);
    send_request(CMD_LOAD, value_t'(VAL_MIN), 3'd0, 1'b0);
    send_request(CMD_LOAD, value_t'(5),       3'd7, 1'b0);
    send_request(CMD_LOAD, value_t'(100),     3'd0, 1'b0);
    send_request(CMD_LOAD, value_t'(VAL_MAX), 3'd0, 1'b0);
    send_request(CMD_LOAD, value_t'(5),       3'd0, 1'b0);
    send_request(CMD_LOAD, value_t'(-100),    3'd0, 1'b0);
    send_request(CMD_LOAD, value_t'(0),       3'd0, 1'b1);
    // restore with the stored ranges, the low end saturates
    send_request(CMD_DENORM, value_t'(VAL_MAX), 3'd0, 1'b1);
    send_request(CMD_DENORM, value_t'(VAL_MIN), 3'd0, 1'b1);
    send_request(CMD_DENORM, value_t'(16384),   3'd1, 1'b1);
    send_request(CMD_DENORM, value_t'(VAL_MIN), 3'd2, 1'b1);
    wait_idle();
  endtask

  // one column wide: the ninth row is dropped and flagged on the final result
  task automatic test_row_overflow();
    write_row_width(4'd1);
    for (int i = 0; i < MAX_ROWS + 1; i++)
      send_request(CMD_LOAD, value_t'(i * 1000 - 4000), 3'd0, i == MAX_ROWS);
    wait_idle();
  endtask

  // width register at zero acts as one; denormalize in the middle of a load
  task automatic test_zero_width_midload_denorm();
    write_row_width(4'd0);
    send_request(CMD_LOAD, value_t'(-256), 3'd0, 1'b0);
    send_request(CMD_DENORM, value_t'(8192), 3'd0, 1'b0);
    send_request(CMD_LOAD, value_t'(256), 3'd0, 1'b1);
    wait_idle();
  endtask

  // receiver holds off while a full 8x8 matrix and more requests pile up
  task automatic test_backpressure();
    write_row_width(4'd15);
    send_idle_pct = 0;
    hold_cycles   = 600;
    for (int i = 0; i < MAX_ROWS * MAX_COLS; i++)
      send_request(CMD_LOAD, value_t'($urandom), COL_NUM_W'($urandom_range(7)),
                   i == MAX_ROWS * MAX_COLS - 1);
    for (int i = 0; i < 4; i++)
      send_request(CMD_DENORM, value_t'($urandom), COL_NUM_W'($urandom_range(7)), 1'b1);
    wait_idle();
    send_idle_pct = 6;
  endtask

  // random widths and matrices; a stretch in the middle runs without gaps
  task automatic test_random_matrices();
    int phase, goal;
    logic [CFG_W-1:0] width;
    phase = 0;
    goal  = requests_sent + RANDOM_ITEMS;
    while (requests_sent < goal) begin
      case ($urandom_range(5))
        0: width = 4'd0;
        1: width = 4'd15;
        2: width = 4'd8;
        default: width = CFG_W'($urandom_range(15));
      endcase
      write_row_width(width);
      send_idle_pct = (phase >= 4 && phase < 9) ? 0 : 6;
      recv_idle_pct = (phase >= 4 && phase < 9) ? 0 : 6;
      repeat ($urandom_range(1, 3)) run_random_matrix();
      wait_idle();
      phase++;
    end
    send_idle_pct = 6;
    recv_idle_pct = 6;
  endtask

  initial begin
    for (int i = 0; i < MAX_ROWS * MAX_COLS; i++) stored_sample[i] = '0;
    for (int i = 0; i < MAX_COLS; i++) begin
      col_lo[i] = '0;
      col_hi[i] = '0;
    end
    rows_seen     = 0;
    cols_seen     = 0;
    rows_dropped  = 1'b0;
    row_width_reg = 4'd8;
    mismatches    = 0;
    requests_sent = 0;
    cycle_count   = 0;
    send_idle_pct = 6;
    recv_idle_pct = 6;
    hold_cycles   = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    test_denorm_after_reset();
    test_extremes_and_flat_column();
    test_row_overflow();
    test_zero_width_midload_denorm();
    test_backpressure();
    test_random_matrices();
    wait_idle();

    if (mismatches == 0 && scaled_outputs.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/cmmn_pkg.sv
rtl/column_min_max_normalizer_core.sv
sim/column_min_max_normalizer_core_tb.sv
